### rtl/gcdp_pkg.sv
// shared constants, types and neighbour helpers for the grid cell division unit
package gcdp_pkg;

   localparam int GRID_SIZE  = 64;
   localparam int ID_W       = 16;
   localparam int WORD_W     = 32;
   localparam int SITES      = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W     = $clog2(SITES);
   localparam int DIR_COUNT  = 8;
   localparam int DATA_W     = 1 + 4 * WORD_W;
   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 168;
   localparam int KIND_W     = 2;
   localparam int STAT_W     = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_DIVIDE = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_READ   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_FREE   = 3'd0,
      STAT_PUSH   = 3'd1,
      STAT_EDGE   = 3'd2,
      STAT_FULL   = 3'd3,
      STAT_ACCESS = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_SCAN, ST_CHOOSE, ST_MOD, ST_FREE_PLACE,
      ST_WALK_RD, ST_WALK_CHK, ST_SHIFT_RD, ST_SHIFT_WR, ST_PUSH_PLACE, ST_DONE
   } state_type;

   // row-major neighbour order, centre skipped; 2'b11 is minus one
   function automatic logic [1:0] step_row(input logic [2:0] dir);
      logic [1:0] s;
      case (dir)
         3'd0, 3'd1, 3'd2: s = 2'b11;
         3'd3, 3'd4:       s = 2'b00;
         default:          s = 2'b01;
      endcase
      return s;
   endfunction

   function automatic logic [1:0] step_col(input logic [2:0] dir);
      logic [1:0] s;
      case (dir)
         3'd0, 3'd3, 3'd5: s = 2'b11;
         3'd1, 3'd6:       s = 2'b00;
         default:          s = 2'b01;
      endcase
      return s;
   endfunction

   function automatic logic [9:0] add_step(input logic [7:0] v, input logic [1:0] s);
      return {2'b00, v} + {{8{s[1]}}, s};
   endfunction

   function automatic logic [9:0] sub_step(input logic [7:0] v, input logic [1:0] s);
      return {2'b00, v} - {{8{s[1]}}, s};
   endfunction

   function automatic logic coord_ok(input logic [9:0] x);
      return !x[9] && (x < 10'(GRID_SIZE));
   endfunction

   function automatic logic [ADDR_W-1:0] site_addr(input logic [7:0] r, input logic [7:0] c);
      return ADDR_W'(r * GRID_SIZE + c);
   endfunction

endpackage

### rtl/gcdp_ram.sv
// generic single-port-write, single-port-read ram with registered read
module gcdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/grid_cell_division_with_push_unit.sv
// top level: grid of cell sites with divide, push, write and read words
//
// channel  | dir | tdata (low bit up)                                   | tuser
// req_     | in  | row, col, random_value, write_cell_id, write_live,   | kind
//          |     | write_substrate_demand, write_oxygen_demand,         |
//          |     | write_substrate_rate, write_oxygen_rate              |
// rsp_     | out | out_row, out_col, out_cell_id, out_live,             | status
//          |     | out_substrate_demand, out_oxygen_demand,             |
//          |     | out_substrate_rate, out_oxygen_rate                  |
//
// one item at a time: a write, a read, a divide into a free neighbour (eight id reads,
// then an 8-step remainder), or a push that walks sites and shifts ids, all bounded
// by the single id ram port pair.
// after reset a clearing pass writes all GRID_SIZE*GRID_SIZE sites with req_tready low.
// a result waits in an output register; the next word is taken meanwhile.
module grid_cell_division_with_push_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row, col, random_value, write_cell_id, write_live, write_substrate_demand,
   // write_oxygen_demand, write_substrate_rate, write_oxygen_rate, zero pad
   input  logic [gcdp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind
   input  logic [gcdp_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_row, out_col, out_cell_id, out_live, out_substrate_demand,
   // out_oxygen_demand, out_substrate_rate, out_oxygen_rate, zero pad
   output logic [gcdp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [gcdp_pkg::STAT_W-1:0]       rsp_tuser
);
   import gcdp_pkg::*;

   state_type state_ff, state_in;

   logic [7:0]        row_ff, row_in, col_ff, col_in, rnd_ff, rnd_in;
   logic              read_ok_ff, read_ok_in;
   logic [3:0]        k_ff, k_in;
   logic              pend_ok_ff, pend_ok_in;
   logic [7:0]        mask_ff, mask_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [4:0]        rem_ff, rem_in;
   logic [2:0]        bit_ff, bit_in;
   logic [2:0]        dir_ff, dir_in;
   logic [7:0]        cur_r_ff, cur_r_in, cur_c_ff, cur_c_in;
   logic [7:0]        nxt_r_ff, nxt_r_in, nxt_c_ff, nxt_c_in;
   status_type        status_ff, status_in;
   logic [7:0]        ores_r_ff, ores_r_in, ores_c_ff, ores_c_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [DATA_W-1:0] mdata_ff, mdata_in;
   logic              mpend_ff, mpend_in;
   logic [ID_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0] rsp_user_ff, rsp_user_in;

   logic              id_we, dat_we;
   logic [ADDR_W-1:0] id_waddr, id_raddr, dat_waddr, dat_raddr;
   logic [ID_W-1:0]   id_wdata, id_rdata;
   logic [DATA_W-1:0] dat_wdata, dat_rdata;

   gcdp_ram #(.WIDTH(ID_W), .DEPTH(SITES)) u_id_ram (
      .clock(clock), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
      .raddr(id_raddr), .rdata(id_rdata)
   );

   gcdp_ram #(.WIDTH(DATA_W), .DEPTH(SITES)) u_data_ram (
      .clock(clock), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
      .raddr(dat_raddr), .rdata(dat_rdata)
   );

   // request fields
   logic [7:0]        q_row, q_col, q_rnd;
   logic [ID_W-1:0]   q_id;
   logic [DATA_W-1:0] q_data;
   logic              q_on;
   assign q_row  = req_tdata[7:0];
   assign q_col  = req_tdata[15:8];
   assign q_rnd  = req_tdata[23:16];
   assign q_id   = req_tdata[39:24];
   assign q_data = req_tdata[168:40];
   assign q_on   = (q_row < 8'(GRID_SIZE)) && (q_col < 8'(GRID_SIZE));

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // scan neighbour, push step and chosen free neighbour
   logic [9:0] scan_r, scan_c, walk_r, walk_c, back_r, back_c, pick_r, pick_c;
   logic [9:0] dgt_r, dgt_c;
   logic       scan_on;
   logic [2:0] sel_k;
   logic [3:0] seen;
   logic [4:0] rem_sh;

   always_comb begin
      scan_r  = add_step(row_ff, step_row(k_ff[2:0]));
      scan_c  = add_step(col_ff, step_col(k_ff[2:0]));
      scan_on = coord_ok(scan_r) && coord_ok(scan_c);
      walk_r  = add_step(cur_r_ff, step_row(dir_ff));
      walk_c  = add_step(cur_c_ff, step_col(dir_ff));
      back_r  = sub_step(cur_r_ff, step_row(dir_ff));
      back_c  = sub_step(cur_c_ff, step_col(dir_ff));
      dgt_r   = add_step(row_ff, step_row(dir_ff));
      dgt_c   = add_step(col_ff, step_col(dir_ff));
      rem_sh  = {rem_ff[3:0], rnd_ff[bit_ff]};
      sel_k   = 3'd0;
      seen    = 4'd0;
      for (int j = 0; j < DIR_COUNT; j++) begin
         if (mask_ff[j]) begin
            if (seen == {1'b0, rem_ff[2:0]}) begin
               sel_k = 3'(j);
            end
            seen = seen + 4'd1;
         end
      end
      pick_r  = add_step(row_ff, step_row(sel_k));
      pick_c  = add_step(col_ff, step_col(sel_k));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(SITES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DONE;
               if (req_tuser == KIND_DIVIDE && q_on && count_ff != '1) state_in = ST_SCAN;
               if (req_tuser == KIND_READ && q_on) state_in = ST_RDWAIT;
            end
         end
         ST_RDWAIT:     state_in = ST_DONE;
         ST_SCAN:       if (k_ff == 4'd8) state_in = ST_CHOOSE;
         ST_CHOOSE:     state_in = (mask_ff == 8'd0) ? ST_WALK_RD : ST_MOD;
         ST_MOD:        if (bit_ff == 3'd0) state_in = ST_FREE_PLACE;
         ST_FREE_PLACE: state_in = ST_DONE;
         ST_WALK_RD: begin
            state_in = (coord_ok(walk_r) && coord_ok(walk_c)) ? ST_WALK_CHK : ST_DONE;
         end
         ST_WALK_CHK: begin
            if (id_rdata != '0) state_in = ST_WALK_RD;
            else if (cur_r_ff == row_ff && cur_c_ff == col_ff) state_in = ST_PUSH_PLACE;
            else state_in = ST_SHIFT_RD;
         end
         ST_SHIFT_RD:   state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            if (back_r[7:0] == row_ff && back_c[7:0] == col_ff) state_in = ST_PUSH_PLACE;
            else state_in = ST_SHIFT_RD;
         end
         ST_PUSH_PLACE: state_in = ST_DONE;
         ST_DONE:       if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      row_in = row_ff;  col_in = col_ff;  rnd_in = rnd_ff;
      read_ok_in = read_ok_ff;  k_in = k_ff;  pend_ok_in = pend_ok_ff;
      mask_in = mask_ff;  cnt_in = cnt_ff;  rem_in = rem_ff;  bit_in = bit_ff;
      dir_in = dir_ff;  cur_r_in = cur_r_ff;  cur_c_in = cur_c_ff;
      nxt_r_in = nxt_r_ff;  nxt_c_in = nxt_c_ff;  status_in = status_ff;
      ores_r_in = ores_r_ff;  ores_c_in = ores_c_ff;  res_id_in = res_id_ff;
      mdata_in = mpend_ff ? dat_rdata : mdata_ff;
      mpend_in = 1'b0;
      count_in = count_ff;
      clr_in = clr_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      id_we = 1'b0;  id_waddr = '0;  id_wdata = '0;  id_raddr = '0;
      dat_we = 1'b0; dat_waddr = '0; dat_wdata = '0; dat_raddr = '0;

      case (state_ff)
         ST_CLEAR: begin
            id_we = 1'b1;  id_waddr = clr_ff;
            dat_we = 1'b1; dat_waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               row_in = q_row;  col_in = q_col;  rnd_in = q_rnd;
               ores_r_in = q_row;  ores_c_in = q_col;
               res_id_in = '0;  read_ok_in = 1'b0;
               status_in = STAT_ACCESS;
               k_in = 4'd0;
               dat_raddr = site_addr(q_row, q_col);
               id_raddr  = site_addr(q_row, q_col);
               case (req_tuser)
                  KIND_DIVIDE: begin
                     if (!q_on) status_in = STAT_EDGE;
                     else if (count_ff == '1) status_in = STAT_FULL;
                     else mpend_in = 1'b1;
                  end
                  KIND_WRITE: begin
                     id_we = q_on;  id_waddr = site_addr(q_row, q_col);  id_wdata = q_id;
                     dat_we = q_on; dat_waddr = site_addr(q_row, q_col); dat_wdata = q_data;
                  end
                  KIND_READ: begin
                     read_ok_in = q_on;
                     mpend_in = q_on;
                  end
                  default: ;
               endcase
            end
         end
         ST_RDWAIT: res_id_in = id_rdata;
         ST_SCAN: begin
            id_raddr = site_addr(scan_r[7:0], scan_c[7:0]);
            pend_ok_in = scan_on && (k_ff != 4'd8);
            if (k_ff != 4'd0) mask_in[3'(k_ff - 4'd1)] = pend_ok_ff && (id_rdata == '0);
            k_in = k_ff + 4'd1;
         end
         ST_CHOOSE: begin
            cnt_in = 4'($countones(mask_ff));
            rem_in = 5'd0;
            bit_in = 3'd7;
            dir_in = rnd_ff[2:0];
            cur_r_in = row_ff;
            cur_c_in = col_ff;
         end
         ST_MOD: begin
            rem_in = (rem_sh >= {1'b0, cnt_ff}) ? rem_sh - {1'b0, cnt_ff} : rem_sh;
            bit_in = bit_ff - 3'd1;
         end
         ST_FREE_PLACE: begin
            id_we = 1'b1;  id_waddr = site_addr(pick_r[7:0], pick_c[7:0]);
            id_wdata = count_ff + 1'b1;
            dat_we = 1'b1; dat_waddr = id_waddr;
            dat_wdata = {mdata_ff[DATA_W-1:1], 1'b1};
            count_in = count_ff + 1'b1;
            res_id_in = count_ff + 1'b1;
            ores_r_in = pick_r[7:0];
            ores_c_in = pick_c[7:0];
            status_in = STAT_FREE;
         end
         ST_WALK_RD: begin
            id_raddr = site_addr(walk_r[7:0], walk_c[7:0]);
            nxt_r_in = walk_r[7:0];
            nxt_c_in = walk_c[7:0];
            // ray meets the edge before a free site
            if (!(coord_ok(walk_r) && coord_ok(walk_c))) status_in = STAT_EDGE;
         end
         ST_WALK_CHK: begin
            if (id_rdata != '0) begin
               cur_r_in = nxt_r_ff;
               cur_c_in = nxt_c_ff;
            end
         end
         ST_SHIFT_RD: id_raddr = site_addr(cur_r_ff, cur_c_ff);
         ST_SHIFT_WR: begin
            id_we = 1'b1;
            id_waddr = site_addr(walk_r[7:0], walk_c[7:0]);
            id_wdata = id_rdata;
            cur_r_in = back_r[7:0];
            cur_c_in = back_c[7:0];
         end
         ST_PUSH_PLACE: begin
            id_we = 1'b1;  id_waddr = site_addr(dgt_r[7:0], dgt_c[7:0]);
            id_wdata = count_ff + 1'b1;
            dat_we = 1'b1; dat_waddr = id_waddr;
            dat_wdata = {mdata_ff[DATA_W-1:1], 1'b1};
            count_in = count_ff + 1'b1;
            res_id_in = count_ff + 1'b1;
            ores_r_in = dgt_r[7:0];
            ores_c_in = dgt_c[7:0];
            status_in = STAT_PUSH;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {7'd0, read_ok_ff ? mdata_ff : {DATA_W{1'b0}},
                               res_id_ff, ores_c_ff, ores_r_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mpend_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         mpend_ff     <= mpend_in;
      end
      row_ff <= row_in;  col_ff <= col_in;  rnd_ff <= rnd_in;
      read_ok_ff <= read_ok_in;  k_ff <= k_in;  pend_ok_ff <= pend_ok_in;
      mask_ff <= mask_in;  cnt_ff <= cnt_in;  rem_ff <= rem_in;  bit_ff <= bit_in;
      dir_ff <= dir_in;  cur_r_ff <= cur_r_in;  cur_c_ff <= cur_c_in;
      nxt_r_ff <= nxt_r_in;  nxt_c_ff <= nxt_c_in;  status_ff <= status_in;
      ores_r_ff <= ores_r_in;  ores_c_ff <= ores_c_in;  res_id_ff <= res_id_in;
      mdata_ff <= mdata_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

### rtl/gcdp_checker.sv
// port-level checks on the grid cell division unit, bound to the top level
module gcdp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gcdp_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [gcdp_pkg::KIND_W-1:0]     req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gcdp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [gcdp_pkg::STAT_W-1:0]     rsp_tuser
);
   import gcdp_pkg::*;

   // a stalled result word stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word dropped or changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("activity straight after reset");

   // only reads carry site contents
   a_div_words: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_ACCESS |-> rsp_tdata[160:32] == '0)
      else $error("divide result carries site words");

   a_fail_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_EDGE || rsp_tuser == STAT_FULL)
      |-> rsp_tdata[31:16] == '0)
      else $error("refused divide reports an id");

   a_new_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_FREE || rsp_tuser == STAT_PUSH)
      |-> rsp_tdata[31:16] != '0)
      else $error("placed daughter without an id");
endmodule

bind grid_cell_division_with_push_unit gcdp_checker u_gcdp_checker (.*);

### tb/grid_cell_division_with_push_checker.sv
// checker for the grid cell division unit: predicts every result word and compares it
`timescale 1ns / 1ps
module grid_cell_division_with_push_checker
   import gcdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [STAT_W-1:0]     rsp_tuser,
   output int                    pending,
   output int                    fail_count
);

   localparam logic [ID_W-1:0] ID_FULL = '1;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [7:0]        row;
      logic [7:0]        col;
      logic [ID_W-1:0]   cell_id;
      logic              live;
      logic [WORD_W-1:0] sub_demand;
      logic [WORD_W-1:0] oxy_demand;
      logic [WORD_W-1:0] sub_rate;
      logic [WORD_W-1:0] oxy_rate;
   } site_result_type;

   logic [ID_W-1:0]   grid_id   [SITES];
   logic              grid_live [SITES];
   logic [WORD_W-1:0] grid_sd   [SITES];
   logic [WORD_W-1:0] grid_od   [SITES];
   logic [WORD_W-1:0] grid_sr   [SITES];
   logic [WORD_W-1:0] grid_or   [SITES];
   logic [ID_W-1:0]   cell_count;

   site_result_type expected_results[$];

   const int dir_row[DIR_COUNT] = '{-1, -1, -1, 0, 0, 1, 1, 1};
   const int dir_col[DIR_COUNT] = '{-1, 0, 1, -1, 1, -1, 0, 1};

   function automatic bit on_grid(int r, int c);
      return r >= 0 && r < GRID_SIZE && c >= 0 && c < GRID_SIZE;
   endfunction

   function automatic bit site_free(int r, int c);
      return on_grid(r, c) && grid_id[r * GRID_SIZE + c] == '0;
   endfunction

   function automatic void place_daughter(int mother, int r, int c);
      int d;
      d = r * GRID_SIZE + c;
      cell_count   = cell_count + 1'b1;
      grid_id[d]   = cell_count;
      grid_live[d] = 1'b1;
      grid_sd[d]   = grid_sd[mother];
      grid_od[d]   = grid_od[mother];
      grid_sr[d]   = grid_sr[mother];
      grid_or[d]   = grid_or[mother];
   endfunction

   function automatic site_result_type divide_cell(int row, int col, int rnd,
                                                   site_result_type res);
      int mother, n_free, pick, k, dir, r, c, dr, dc;
      n_free = 0;
      if (!on_grid(row, col)) begin
         res.status = STAT_EDGE;
         return res;
      end
      if (cell_count >= ID_FULL) begin
         res.status = STAT_FULL;
         return res;
      end
      mother = row * GRID_SIZE + col;
      for (k = 0; k < DIR_COUNT; k++)
         if (site_free(row + dir_row[k], col + dir_col[k])) n_free++;
      if (n_free > 0) begin
         pick = rnd % n_free;
         for (k = 0; k < DIR_COUNT; k++) begin
            r = row + dir_row[k];
            c = col + dir_col[k];
            if (site_free(r, c)) begin
               if (pick == 0) break;
               pick--;
            end
         end
         place_daughter(mother, r, c);
         res.status  = STAT_FREE;
         res.row     = 8'(r);
         res.col     = 8'(c);
         res.cell_id = cell_count;
         return res;
      end
      dir = rnd % DIR_COUNT;
      dr  = dir_row[dir];
      dc  = dir_col[dir];
      r   = row;
      c   = col;
      // find the last occupied site on the ray
      while (on_grid(r + dr, c + dc) && grid_id[(r + dr) * GRID_SIZE + c + dc] != '0) begin
         r += dr;
         c += dc;
      end
      if (!on_grid(r + dr, c + dc)) begin
         res.status = STAT_EDGE;
         return res;
      end
      // only ids move outward
      while (r != row || c != col) begin
         grid_id[(r + dr) * GRID_SIZE + c + dc] = grid_id[r * GRID_SIZE + c];
         r -= dr;
         c -= dc;
      end
      place_daughter(mother, row + dr, col + dc);
      res.status  = STAT_PUSH;
      res.row     = 8'(row + dr);
      res.col     = 8'(col + dc);
      res.cell_id = cell_count;
      return res;
   endfunction

   function automatic site_result_type predict_word(logic [KIND_W-1:0] kind,
                                                    logic [REQ_DATA_W-1:0] d);
      site_result_type res;
      int row, col, s;
      res     = '0;
      row     = d[7:0];
      col     = d[15:8];
      res.row = d[7:0];
      res.col = d[15:8];
      if (kind == KIND_DIVIDE) return divide_cell(row, col, d[23:16], res);
      res.status = STAT_ACCESS;
      if (kind == KIND_NONE || !on_grid(row, col)) return res;
      s = row * GRID_SIZE + col;
      if (kind == KIND_WRITE) begin
         grid_id[s]   = d[39:24];
         grid_live[s] = d[40];
         grid_sd[s]   = d[72:41];
         grid_od[s]   = d[104:73];
         grid_sr[s]   = d[136:105];
         grid_or[s]   = d[168:137];
      end else begin
         res.cell_id    = grid_id[s];
         res.live       = grid_live[s];
         res.sub_demand = grid_sd[s];
         res.oxy_demand = grid_od[s];
         res.sub_rate   = grid_sr[s];
         res.oxy_rate   = grid_or[s];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      site_result_type got, want;
      if (reset) begin
         for (int i = 0; i < SITES; i++) begin
            grid_id[i]   = '0;
            grid_live[i] = 1'b0;
            grid_sd[i]   = '0;
            grid_od[i]   = '0;
            grid_sr[i]   = '0;
            grid_or[i]   = '0;
         end
         cell_count = '0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_word(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[31:16], rsp_tdata[32],
                   rsp_tdata[64:33], rsp_tdata[96:65], rsp_tdata[128:97], rsp_tdata[160:129]};
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result word: %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.row !== want.row || got.col !== want.col ||
                   got.cell_id !== want.cell_id || got.live !== want.live ||
                   got.sub_demand !== want.sub_demand || got.oxy_demand !== want.oxy_demand ||
                   got.sub_rate !== want.sub_rate || got.oxy_rate !== want.oxy_rate) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: expected %p", want);
                     $display("          actual   %p", got);
                  end
               end
            end
         end
      end
      pending <= expected_results.size();
   end

   initial begin
      pending    = 0;
      fail_count = 0;
   end

endmodule

### tb/grid_cell_division_with_push_unit_test.sv
// testbench top: stimulus, receiver stalls and verdict for the grid cell division unit
`timescale 1ns / 1ps
module grid_cell_division_with_push_unit_test;
   import gcdp_pkg::*;

   localparam int CYCLE_LIMIT = 900000;
   localparam int RANDOM_WORDS = 450;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = KIND_NONE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   int  pending, fail_count, cycles;
   bit  idle_on = 1'b1;
   bit  long_hold_req = 1'b0;
   int  hold_left = 0;

   grid_cell_division_with_push_unit i_dut (.*);

   grid_cell_division_with_push_checker i_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_on && $urandom_range(99) < 27);
      end
   end

   task automatic send_word(kind_type kind, logic [7:0] row, logic [7:0] col, logic [7:0] rnd,
                            logic [15:0] id, logic live, logic [31:0] sd, logic [31:0] od,
                            logic [31:0] sr, logic [31:0] orate);
      if (idle_on && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 27) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, orate, sr, od, sd, live, id, rnd, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic divide_at(int row, int col, int rnd);
      send_word(KIND_DIVIDE, 8'(row), 8'(col), 8'(rnd), 16'($urandom), 1'($urandom),
                $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      int pick, row, col;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, extremes, off-grid accesses, unused kind
      send_word(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(KIND_WRITE, 0, 0, 8'hff, 16'hffff, 1, '1, '1, '1, '1);
      send_word(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(KIND_WRITE, 63, 63, 0, 0, 0, $urandom, $urandom, $urandom, $urandom);
      send_word(KIND_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0);
      send_word(KIND_WRITE, 64, 200, 0, 16'h1234, 1, '1, '1, '1, '1);
      send_word(KIND_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0);
      send_word(KIND_NONE, 5, 5, 8'hff, 16'hffff, 1, '1, '1, '1, '1);
      divide_at(100, 5, 3);
      divide_at(5, 255, 3);
      divide_at(30, 30, 255);
      // fill round the corner so the later ones push or hit the edge
      for (int i = 0; i < 12; i++) divide_at(0, 0, i);
      divide_at(0, 1, 4);
      divide_at(1, 1, 7);
      drain_results();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 150) long_hold_req = 1'b1;
         if (n == 200) idle_on = 1'b0;
         if (n == 280) idle_on = 1'b1;
         if (n == 320) drain_results();
         pick = $urandom_range(99);
         // crowd two small patches so neighbours fill and pushes happen
         if ($urandom_range(1)) begin
            row = $urandom_range(6);
            col = $urandom_range(6);
         end else begin
            row = $urandom_range(63, 57);
            col = $urandom_range(40, 34);
         end
         if (pick < 60) begin
            divide_at(row, col, $urandom_range(255));
         end else if (pick < 73) begin
            send_word(KIND_WRITE, 8'(row), 8'(col), 8'($urandom),
                      $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3)),
                      1'($urandom), $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 90) begin
            send_word(KIND_READ, 8'(row), 8'(col), 8'($urandom), 16'($urandom),
                      1'($urandom), $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 94) begin
            send_word(KIND_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                      1'($urandom), $urandom, $urandom, $urandom, $urandom);
         end else begin
            send_word(kind_type'($urandom_range(2)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom), 16'($urandom), 1'($urandom),
                      $urandom, $urandom, $urandom, $urandom);
         end
      end
      drain_results();

      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
